// ----- design/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Receive message deframer package
// Shared types, character constants and small decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rmd_pkg;

    localparam int MAX_SIZE_DIGITS = 5;
    localparam int SIZE_W          = 17;
    localparam int DCNT_W          = 3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_PFX1   = 4'd1,
        PH_PFX2   = 4'd2,
        PH_PFX3   = 4'd3,
        PH_PFX4   = 4'd4,
        PH_PFX5   = 4'd5,
        PH_PFX6   = 4'd6,
        PH_PFX7   = 4'd7,
        PH_SIZE   = 4'd8,
        PH_DATA   = 4'd9,
        PH_REJECT = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_LOW  = 2'd1,
        ESC_HIGH = 2'd2
    } t_esc;

    // One decoded payload byte, as handed from the parser to the output stage.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
    } t_result;

    // Expected character at each position of the "RECV 15 " prefix.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h52; // R
            3'd1:    ch = 8'h45; // E
            3'd2:    ch = 8'h43; // C
            3'd3:    ch = 8'h56; // V
            3'd4:    ch = 8'h20; // space
            3'd5:    ch = 8'h31; // 1
            3'd6:    ch = 8'h35; // 5
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

    // Upper-case hex digit decode: bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = {1'b0, 4'(c - CH_ZERO)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = {1'b0, 4'(c - CH_UA + 8'd10)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/rmd_parser.sv -----
// ----------------------------------------------------------------------------
// Deframer parser
// Holds the framing state and decodes one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    output rmd_pkg::t_result   o_res
);

    rmd_pkg::t_phase                    r_phase, n_phase;
    logic [rmd_pkg::SIZE_W-1:0]         r_size, n_size;
    logic [rmd_pkg::DCNT_W-1:0]         r_dcnt, n_dcnt;
    logic [rmd_pkg::SIZE_W-1:0]         r_pcnt, n_pcnt;
    rmd_pkg::t_esc                      r_esc, n_esc;
    logic [3:0]                         r_nib, n_nib;

    logic [4:0]                         hex_v;
    logic [rmd_pkg::SIZE_W-1:0]         size_mul;
    logic [rmd_pkg::SIZE_W-1:0]         pcnt_inc;
    logic [rmd_pkg::DCNT_W-1:0]         dcnt_inc;
    logic                               is_digit;

    assign hex_v    = rmd_pkg::hex_value(i_byte);
    assign is_digit = (i_byte >= rmd_pkg::CH_ZERO) && (i_byte <= rmd_pkg::CH_NINE);
    assign size_mul = (r_size << 3) + (r_size << 1)
                    + rmd_pkg::SIZE_W'(i_byte - rmd_pkg::CH_ZERO);
    assign pcnt_inc = r_pcnt + 1'b1;
    assign dcnt_inc = r_dcnt + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_size  = r_size;
        n_dcnt  = r_dcnt;
        n_pcnt  = r_pcnt;
        n_esc   = r_esc;
        n_nib   = r_nib;
        o_res   = '{emit: 1'b0, data: i_byte, last: 1'b0};

        if (r_phase != rmd_pkg::PH_DATA && i_byte == rmd_pkg::CH_CR) begin
            n_phase = rmd_pkg::PH_IDLE;
            n_size  = '0;
            n_dcnt  = '0;
            n_pcnt  = '0;
            n_esc   = rmd_pkg::ESC_NONE;
        end else begin
            case (r_phase)
                rmd_pkg::PH_IDLE: begin
                    if (i_byte == rmd_pkg::prefix_char(3'd0)) begin
                        n_phase = rmd_pkg::PH_PFX1;
                    end
                end
                rmd_pkg::PH_PFX1, rmd_pkg::PH_PFX2, rmd_pkg::PH_PFX3,
                rmd_pkg::PH_PFX4, rmd_pkg::PH_PFX5, rmd_pkg::PH_PFX6,
                rmd_pkg::PH_PFX7: begin
                    if (i_byte == rmd_pkg::prefix_char(r_phase[2:0])) begin
                        n_phase = rmd_pkg::t_phase'(r_phase + 4'd1);
                    end else begin
                        n_phase = rmd_pkg::PH_REJECT;
                        n_size  = '0;
                        n_dcnt  = '0;
                        n_esc   = rmd_pkg::ESC_NONE;
                    end
                end
                rmd_pkg::PH_SIZE: begin
                    if (i_byte == rmd_pkg::CH_SPACE) begin
                        if (r_size == '0) begin
                            n_phase = rmd_pkg::PH_IDLE;
                            n_pcnt  = '0;
                        end else begin
                            n_phase = rmd_pkg::PH_DATA;
                            n_pcnt  = '0;
                        end
                        n_dcnt = '0;
                        n_esc  = rmd_pkg::ESC_NONE;
                    end else if (is_digit &&
                                 32'(dcnt_inc) < rmd_pkg::MAX_SIZE_DIGITS + 1) begin
                        n_size = size_mul;
                        n_dcnt = dcnt_inc;
                    end else begin
                        n_phase = rmd_pkg::PH_REJECT;
                        n_size  = '0;
                        n_dcnt  = '0;
                        n_esc   = rmd_pkg::ESC_NONE;
                    end
                end
                rmd_pkg::PH_DATA: begin
                    if (r_esc == rmd_pkg::ESC_NONE) begin
                        if (i_byte == rmd_pkg::CH_ESC) begin
                            n_esc = rmd_pkg::ESC_HIGH;
                        end else begin
                            o_res.emit = 1'b1;
                        end
                    end else if (!hex_v[4]) begin
                        if (r_esc == rmd_pkg::ESC_HIGH) begin
                            n_esc = rmd_pkg::ESC_LOW;
                            n_nib = hex_v[3:0];
                        end else begin
                            n_esc      = rmd_pkg::ESC_NONE;
                            o_res.emit = 1'b1;
                            o_res.data = {r_nib, hex_v[3:0]};
                        end
                    end else begin
                        n_phase = rmd_pkg::PH_REJECT;
                        n_size  = '0;
                        n_dcnt  = '0;
                        n_esc   = rmd_pkg::ESC_NONE;
                    end
                    if (o_res.emit) begin
                        n_pcnt = pcnt_inc;
                        if (pcnt_inc == r_size) begin
                            o_res.last = 1'b1;
                            n_phase    = rmd_pkg::PH_IDLE;
                            n_size     = '0;
                            n_dcnt     = '0;
                            n_pcnt     = '0;
                            n_esc      = rmd_pkg::ESC_NONE;
                        end
                    end
                end
                default: begin
                    // Reject and unused codes wait for a carriage return.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rmd_pkg::PH_IDLE;
            r_size  <= '0;
            r_dcnt  <= '0;
            r_pcnt  <= '0;
            r_esc   <= rmd_pkg::ESC_NONE;
            r_nib   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_dcnt  <= n_dcnt;
            r_pcnt  <= n_pcnt;
            r_esc   <= n_esc;
            r_nib   <= n_nib;
        end
    end

endmodule

`default_nettype wire

// ----- design/rmd_out_reg.sv -----
// ----------------------------------------------------------------------------
// Deframer output register
// Holds one decoded byte until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire rmd_pkg::t_result i_res,
    input  wire logic          i_ready,
    output logic               o_room,
    output logic               o_valid,
    output logic [7:0]         o_data,
    output logic               o_last
);

    logic       r_valid, n_valid;
    logic [7:0] r_data;
    logic       r_last;

    assign o_room  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res.data;
            r_last <= i_res.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ----- design/recv_message_deframer.sv -----
// ----------------------------------------------------------------------------
// Receive message deframer
// Strips the "RECV 15 <size> " header from a serial byte stream and emits
// the payload bytes with hex escapes decoded.
// ----------------------------------------------------------------------------
// Usage:
// Raw bytes enter on the rx channel (i_rx_valid / o_rx_ready / i_rx_byte),
// one request per byte. Decoded payload bytes leave on the out channel
// (o_out_valid / i_out_ready) with o_payload_last marking the byte that
// completes the announced size. Header bytes, escape introducers and
// rejected bytes produce no output request.
// Each accepted byte lands in an input register; from there the parser
// decodes it and updates its framing state, and a resulting byte is written
// to the output register, which drives o_out_valid. The block takes one
// byte per cycle while the output register has room for the bytes it emits.
// When the receiver stalls, the output register holds its byte and the
// input register holds one more; a byte that produces no output still moves
// through. o_rx_ready drops only when both are occupied or reset is held.
// Reset (synchronous, active low) returns the parser to idle, awaiting the
// first prefix letter, and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module recv_message_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_data_byte,
    output logic            o_payload_last
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic             rx_acc;
    logic             adv;
    logic             room;
    rmd_pkg::t_result res;

    // The staged byte moves on when it produces nothing or the output has room.
    assign adv        = r_in_valid && (!res.emit || room);
    assign o_rx_ready = i_rst_n && (!r_in_valid || adv);
    assign rx_acc     = i_rx_valid && o_rx_ready;
    assign n_in_valid = rx_acc || (r_in_valid && !adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rmd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    rmd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res.emit),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_data  (o_data_byte),
        .o_last  (o_payload_last)
    );

endmodule

`default_nettype wire

// ----- design/rmd_checker.sv -----
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level assertions on the deframer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_rx_valid,
    input wire logic       o_rx_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_payload_last
);

    // A stalled output request keeps its byte and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_payload_last))
        else $error("output request changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // With the output empty, the input side is never back-pressured.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_rx_ready)
        else $error("input stalled with empty output");

    // A new output request always traces back to an accepted input byte.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_rx_valid && o_rx_ready, 2))
        else $error("output request without a matching input");

endmodule

bind recv_message_deframer rmd_checker u_rmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_valid     (i_rx_valid),
    .o_rx_ready     (o_rx_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_data_byte    (o_data_byte),
    .o_payload_last (o_payload_last)
);

`default_nettype wire

// ----- bench/recv_message_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// Receive message deframer testbench
// Drives framed, malformed and noisy byte streams into the deframer while
// both channels idle at random, and checks every payload byte and its last
// flag against a behavioral parser model in this bench or a typed-in result.
// ----------------------------------------------------------------------------

module recv_message_deframer_tb;

    // Counted random requests after the directed table. Ignored bytes (idle
    // noise, bytes swallowed while rejecting) come on top of this.
    localparam int RANDOM_ITEMS  = 1350;

    // The slowest correct run is roughly 1800 requests and about 700 results,
    // each behind its own random wait, plus two long hold-offs. The limit
    // below leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [63:0] HEADER_TEXT = "RECV 15 ";

    // Directed rows either carry their result typed in, or leave it to the
    // model below.
    localparam logic GIVEN     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [7:0] rx;
        logic       given;
        logic       has_out;
        logic [7:0] out_byte;
        logic       out_last;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_byte;

    // Shapes of random traffic, one frame at a time. Every frame leaves the
    // parser idle again.
    typedef enum int {
        FR_GOOD,
        FR_ZERO_SIZE,
        FR_LONG_SIZE,
        FR_BAD_SIZE_CHAR,
        FR_BAD_PREFIX,
        FR_BAD_HEX,
        FR_HUGE_SIZE,
        FR_NOISE
    } t_frame;

    logic       i_clk      = 1'b0;
    logic       rst_n      = 1'b0;
    logic       rx_valid   = 1'b0;
    logic [7:0] rx_byte    = 8'h00;
    logic       out_ready  = 1'b0;
    logic       rx_ready;
    logic       out_valid;
    logic [7:0] data_byte;
    logic       payload_last;

    recv_message_deframer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_data_byte    (data_byte),
        .o_payload_last (payload_last)
    );

    // Directed part. The first two bytes are the input extremes, sent while
    // idle where anything but 'R' is dropped. Then a three byte payload: a
    // carriage return that is taken literally inside the payload, an "FF"
    // escape for the top output value, and a zero byte that closes the
    // payload. Then a prefix that breaks on its third letter, an 'R' that the
    // reject state must not take as a fresh start, and the carriage return
    // that ends the reject. Last, a carriage return in the middle of the
    // prefix, which returns to idle directly.
    t_stim_row directed_rows [25] = '{
        '{8'h00,             GIVEN,     1'b0, 8'h00, 1'b0},
        '{8'hFF,             GIVEN,     1'b0, 8'h00, 1'b0},
        '{"R",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"E",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"C",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"V",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{" ",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"1",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"5",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{" ",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"3",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{" ",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{rmd_pkg::CH_CR,    GIVEN,     1'b1, 8'h0D, 1'b0},
        '{rmd_pkg::CH_ESC,   GIVEN,     1'b0, 8'h00, 1'b0},
        '{"F",               GIVEN,     1'b0, 8'h00, 1'b0},
        '{"F",               GIVEN,     1'b1, 8'hFF, 1'b0},
        '{8'h00,             GIVEN,     1'b1, 8'h00, 1'b1},
        '{"R",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"E",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"X",               GIVEN,     1'b0, 8'h00, 1'b0},
        '{"R",               GIVEN,     1'b0, 8'h00, 1'b0},
        '{rmd_pkg::CH_CR,    GIVEN,     1'b0, 8'h00, 1'b0},
        '{"R",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{"E",               PREDICTED, 1'b0, 8'h00, 1'b0},
        '{rmd_pkg::CH_CR,    GIVEN,     1'b0, 8'h00, 1'b0}
    };

    t_stim_row     rx_stream_q[$];
    t_payload_byte pending_payload_q[$];
    int            counted_items = 0;
    int            mismatches    = 0;

    // Parser state as the bench tracks it.
    rmd_pkg::t_phase               phase;
    logic [rmd_pkg::SIZE_W-1:0]    announced_size;
    logic [rmd_pkg::DCNT_W-1:0]    digits_seen;
    logic [rmd_pkg::SIZE_W-1:0]    bytes_emitted;
    rmd_pkg::t_esc                 hex_wait;
    logic [3:0]                    hex_hi;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    function automatic logic [7:0] header_char(input int idx);
        return HEADER_TEXT[63 - 8*idx -: 8];
    endfunction

    function automatic void frame_to_idle();
        phase          = rmd_pkg::PH_IDLE;
        announced_size = '0;
        digits_seen    = '0;
        bytes_emitted  = '0;
        hex_wait       = rmd_pkg::ESC_NONE;
    endfunction

    // The emitted count is left alone on a reject; idle clears it later.
    function automatic void frame_to_reject();
        phase          = rmd_pkg::PH_REJECT;
        announced_size = '0;
        digits_seen    = '0;
        hex_wait       = rmd_pkg::ESC_NONE;
    endfunction

    function automatic void deframe_reset();
        frame_to_idle();
        hex_hi = 4'h0;
    endfunction

    // Consumes one received byte and tells whether a payload byte comes out.
    function automatic void deframe_predict(input  logic [7:0] c,
                                            output logic       emit,
                                            output logic [7:0] data,
                                            output logic       last);
        logic       is_hex;
        logic [3:0] nibble;
        emit   = 1'b0;
        data   = 8'h00;
        last   = 1'b0;
        is_hex = 1'b1;
        nibble = 4'h0;
        if (c inside {[rmd_pkg::CH_ZERO:rmd_pkg::CH_NINE]}) begin
            nibble = 4'(c - rmd_pkg::CH_ZERO);
        end else if (c inside {[rmd_pkg::CH_UA:rmd_pkg::CH_UF]}) begin
            nibble = 4'(c - rmd_pkg::CH_UA) + 4'd10;
        end else begin
            is_hex = 1'b0;
        end

        // Outside the payload a carriage return always ends the frame.
        if (phase != rmd_pkg::PH_DATA && c == rmd_pkg::CH_CR) begin
            frame_to_idle();
            return;
        end

        case (phase)
            rmd_pkg::PH_IDLE: begin
                if (c == header_char(0)) phase = rmd_pkg::PH_PFX1;
            end
            rmd_pkg::PH_PFX1, rmd_pkg::PH_PFX2, rmd_pkg::PH_PFX3, rmd_pkg::PH_PFX4,
            rmd_pkg::PH_PFX5, rmd_pkg::PH_PFX6, rmd_pkg::PH_PFX7: begin
                if (c == header_char(int'(phase)))
                    phase = rmd_pkg::t_phase'(phase + 4'd1);
                else frame_to_reject();
            end
            rmd_pkg::PH_SIZE: begin
                if (c == rmd_pkg::CH_SPACE) begin
                    if (announced_size == '0) begin
                        frame_to_idle();
                    end else begin
                        phase         = rmd_pkg::PH_DATA;
                        digits_seen   = '0;
                        bytes_emitted = '0;
                        hex_wait      = rmd_pkg::ESC_NONE;
                    end
                end else if (c inside {[rmd_pkg::CH_ZERO:rmd_pkg::CH_NINE]}) begin
                    announced_size = rmd_pkg::SIZE_W'(announced_size * 10
                                                      + (c - rmd_pkg::CH_ZERO));
                    digits_seen    = digits_seen + 1'b1;
                    if (digits_seen >= rmd_pkg::MAX_SIZE_DIGITS + 1) frame_to_reject();
                end else begin
                    frame_to_reject();
                end
            end
            rmd_pkg::PH_DATA: begin
                if (hex_wait == rmd_pkg::ESC_NONE) begin
                    if (c == rmd_pkg::CH_ESC) begin
                        hex_wait = rmd_pkg::ESC_HIGH;
                    end else begin
                        emit = 1'b1;
                        data = c;
                    end
                end else if (!is_hex) begin
                    frame_to_reject();
                end else if (hex_wait == rmd_pkg::ESC_HIGH) begin
                    hex_hi   = nibble;
                    hex_wait = rmd_pkg::ESC_LOW;
                end else begin
                    hex_wait = rmd_pkg::ESC_NONE;
                    emit     = 1'b1;
                    data     = {hex_hi, nibble};
                end
                if (emit) begin
                    bytes_emitted = bytes_emitted + 1'b1;
                    last = (bytes_emitted == announced_size);
                    if (last) frame_to_idle();
                end
            end
            default: begin
                // Rejecting: only a carriage return, handled above, gets out.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // Idle cycles before the next request, with runs of back-to-back requests.
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic void push_rx(input logic [7:0] b, input logic counts);
        rx_stream_q.push_back('{b, PREDICTED, 1'b0, 8'h00, 1'b0});
        if (counts) counted_items++;
    endfunction

    function automatic void push_header(input int chars);
        for (int i = 0; i < chars; i++) push_rx(header_char(i), 1'b1);
    endfunction

    function automatic void push_size(input int n, input int width);
        int scale;
        scale = 1;
        repeat (width - 1) scale *= 10;
        repeat (width) begin
            push_rx(rmd_pkg::CH_ZERO + 8'((n / scale) % 10), 1'b1);
            scale /= 10;
        end
    endfunction

    // Digits needed for n, sometimes padded with leading zeros up to the max.
    function automatic int padded_width(input int n);
        int ndig;
        ndig = (n >= 10000) ? 5 : (n >= 1000) ? 4 : (n >= 100) ? 3 : (n >= 10) ? 2 : 1;
        if ($urandom_range(0, 3) == 0)
            ndig += $urandom_range(0, rmd_pkg::MAX_SIZE_DIGITS - ndig);
        return ndig;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        return (v < 10) ? rmd_pkg::CH_ZERO + 8'(v) : rmd_pkg::CH_UA + 8'(v - 10);
    endfunction

    // Lower case hex is as wrong as anything else, so it gets a fair share.
    function automatic logic [7:0] bad_hex_char();
        logic [7:0] b;
        if ($urandom_range(0, 2) == 0) return 8'h61 + 8'($urandom_range(0, 5));
        do b = 8'($urandom_range(0, 255));
        while (b inside {[rmd_pkg::CH_ZERO:rmd_pkg::CH_NINE],
                         [rmd_pkg::CH_UA:rmd_pkg::CH_UF]});
        return b;
    endfunction

    // One payload byte: a literal, or an escape that decodes to one byte.
    function automatic void push_payload_item();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == rmd_pkg::CH_ESC || $urandom_range(0, 4) == 0) begin
            push_rx(rmd_pkg::CH_ESC, 1'b1);
            push_rx(hex_char(), 1'b1);
            push_rx(hex_char(), 1'b1);
        end else begin
            push_rx(b, 1'b1);
        end
    endfunction

    // Bytes dropped while rejecting, then the carriage return that ends it.
    function automatic void push_reject_tail();
        logic [7:0] b;
        repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom_range(0, 255));
            while (b == rmd_pkg::CH_CR);
            push_rx(b, 1'b0);
        end
        push_rx(rmd_pkg::CH_CR, 1'b1);
    endfunction

    // Mostly well-formed frames with random content and sizes, so the payload
    // path gets the bulk of the traffic. The first pass walks every frame
    // shape once so each error path is hit in every run.
    function automatic void build_random_traffic();
        int         frames;
        int         pick;
        int         n;
        int         k;
        t_frame     kind;
        logic [7:0] b;
        frames = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (frames <= int'(FR_NOISE)) begin
                kind = t_frame'(frames);
            end else begin
                pick = $urandom_range(0, 99);
                kind = (pick < 60) ? FR_GOOD :
                       (pick < 66) ? FR_ZERO_SIZE :
                       (pick < 72) ? FR_LONG_SIZE :
                       (pick < 78) ? FR_BAD_SIZE_CHAR :
                       (pick < 86) ? FR_BAD_PREFIX :
                       (pick < 94) ? FR_BAD_HEX :
                       (pick < 97) ? FR_HUGE_SIZE : FR_NOISE;
            end
            frames++;
            // A stray carriage return while idle changes nothing.
            if ($urandom_range(0, 9) == 0) push_rx(rmd_pkg::CH_CR, 1'b0);
            case (kind)
                FR_GOOD: begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                    : $urandom_range(1, 12);
                    push_header(8);
                    push_size(n, padded_width(n));
                    push_rx(rmd_pkg::CH_SPACE, 1'b1);
                    repeat (n) push_payload_item();
                end
                FR_ZERO_SIZE: begin
                    // Either no digits at all or a run of zeros.
                    push_header(8);
                    if ($urandom_range(0, 1) == 0)
                        push_size(0, $urandom_range(1, rmd_pkg::MAX_SIZE_DIGITS));
                    push_rx(rmd_pkg::CH_SPACE, 1'b1);
                end
                FR_LONG_SIZE: begin
                    push_header(8);
                    repeat (rmd_pkg::MAX_SIZE_DIGITS + 1)
                        push_rx(rmd_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
                    push_reject_tail();
                end
                FR_BAD_SIZE_CHAR: begin
                    push_header(8);
                    repeat ($urandom_range(0, 3))
                        push_rx(rmd_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {[rmd_pkg::CH_ZERO:rmd_pkg::CH_NINE]}
                           || b == rmd_pkg::CH_SPACE || b == rmd_pkg::CH_CR);
                    push_rx(b, 1'b1);
                    push_reject_tail();
                end
                FR_BAD_PREFIX: begin
                    // Cut the header short with a carriage return or a wrong
                    // letter; a full header can only be cut by the return.
                    k = $urandom_range(1, 8);
                    push_header(k);
                    if (k == 8 || $urandom_range(0, 2) == 0) begin
                        push_rx(rmd_pkg::CH_CR, 1'b1);
                    end else begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == header_char(k) || b == rmd_pkg::CH_CR);
                        push_rx(b, 1'b1);
                        push_reject_tail();
                    end
                end
                FR_BAD_HEX: begin
                    n = $urandom_range(2, 12);
                    push_header(8);
                    push_size(n, padded_width(n));
                    push_rx(rmd_pkg::CH_SPACE, 1'b1);
                    repeat ($urandom_range(0, n - 1)) push_payload_item();
                    push_rx(rmd_pkg::CH_ESC, 1'b1);
                    if ($urandom_range(0, 1) == 0) push_rx(hex_char(), 1'b1);
                    push_rx(bad_hex_char(), 1'b1);
                    push_reject_tail();
                end
                FR_HUGE_SIZE: begin
                    // Five-digit sizes are announced but never sent in full;
                    // a bad escape aborts them after a few bytes.
                    n = ($urandom_range(0, 1) == 0) ? 99999 : $urandom_range(10000, 99999);
                    push_header(8);
                    push_size(n, rmd_pkg::MAX_SIZE_DIGITS);
                    push_rx(rmd_pkg::CH_SPACE, 1'b1);
                    repeat ($urandom_range(0, 3)) push_payload_item();
                    push_rx(rmd_pkg::CH_ESC, 1'b1);
                    push_rx(bad_hex_char(), 1'b1);
                    push_reject_tail();
                end
                default: begin
                    repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)), 1'b0);
                    push_rx(rmd_pkg::CH_CR, 1'b0);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: walks the directed table and then the random traffic. The
    // model is stepped at the edge where a request is taken, so the
    // expected byte is queued before the block can return it.
    // ------------------------------------------------------------------------

    initial begin
        t_stim_row  row;
        int         wait_cycles;
        int         run_left;
        int         waited;
        logic       want_out;
        logic [7:0] want_byte;
        logic       want_last;
        run_left = 0;
        deframe_reset();
        foreach (directed_rows[i]) rx_stream_q.push_back(directed_rows[i]);
        build_random_traffic();

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        while (rx_stream_q.size() != 0) begin
            row = rx_stream_q.pop_front();
            wait_cycles = draw_wait(run_left);
            if (wait_cycles > 0) begin
                rx_valid <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            rx_valid <= 1'b1;
            rx_byte  <= row.rx;
            @(posedge i_clk);
            while (!rx_ready) @(posedge i_clk);

            // The model always runs so its state follows the stream; rows
            // with a typed-in result use that instead of the model's output.
            deframe_predict(row.rx, want_out, want_byte, want_last);
            if (row.given) begin
                want_out  = row.has_out;
                want_byte = row.out_byte;
                want_last = row.out_last;
            end
            if (want_out) pending_payload_q.push_back('{want_byte, want_last});
        end
        rx_valid <= 1'b0;

        waited = 0;
        while (pending_payload_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_payload_q.size() != 0) begin
            $error("%0d payload bytes never came out", pending_payload_q.size());
            mismatches++;
        end
        // Anything the block still sends now is unexpected and is caught by
        // the receiver.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls per request, plus two long hold-offs that let
    // the block fill up and push back on the sender.
    // ------------------------------------------------------------------------

    initial begin
        t_payload_byte want;
        int            wait_cycles;
        int            run_left;
        int            hold;
        int            results;
        run_left = 0;
        results  = 0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (results == 100 || results == 300) begin
                out_ready <= 1'b0;
                hold = 0;
                while (hold < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold++;
                end
            end
            wait_cycles = draw_wait(run_left);
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            results++;

            if (pending_payload_q.size() == 0) begin
                $error("unexpected payload byte: data_byte 8'h%02h, payload_last %0b",
                       data_byte, payload_last);
                mismatches++;
            end else begin
                want = pending_payload_q.pop_front();
                if (data_byte !== want.data) begin
                    $error("data_byte: expected 8'h%02h, got 8'h%02h", want.data, data_byte);
                    mismatches++;
                end
                if (payload_last !== want.last) begin
                    $error("payload_last: expected %0b, got %0b", want.last, payload_last);
                    mismatches++;
                end
            end
        end
    end

endmodule
